// ===== src/mlpf_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpf_pkg
// Shared constants, codes and types of the MLP forward inference core.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpf_pkg;

    localparam int MAX_LAYERS = 4;
    localparam int MAX_NODES  = 16;
    localparam int DATA_WIDTH = 16;

    localparam int LAYER_W = 2;
    localparam int NODE_W  = 4;
    localparam int CNT_W   = 5;
    localparam int MEM_AW  = LAYER_W + NODE_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [1:0] ACT_WEIGHT  = 2'd0;
    localparam logic [1:0] ACT_BIAS    = 2'd1;
    localparam logic [1:0] ACT_FEATURE = 2'd2;

    localparam logic [1:0] KIND_SIGMOID = 2'd0;
    localparam logic [1:0] KIND_RELU    = 2'd1;
    localparam logic [1:0] KIND_SOFTMAX = 2'd2;
    localparam logic [1:0] KIND_ZERO    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LAYERS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUTS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES3 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KINDS  = 3'd6;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef t_data [MAX_NODES-1:0] t_dvec;

    typedef struct packed {
        logic [1:0]        action;
        logic [LAYER_W-1:0] layer_index;
        logic [NODE_W-1:0] node_index;
        logic [NODE_W-1:0] source_index;
        t_data             value;
        logic              last_feature;
    } t_in_item;

    typedef struct packed {
        t_data             result_value;
        logic [NODE_W-1:0] result_index;
        logic              last_result;
    } t_out_item;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [NODE_W-1:0] s;
        t_data             x;
    } t_tok;

    typedef struct packed {
        logic               w_en;
        logic               b_en;
        logic [LAYER_W-1:0] layer;
        logic [NODE_W-1:0]  src;
        t_data              val;
    } t_wr;

    typedef struct packed {
        logic             start;
        logic [1:0]       kind;
        logic [CNT_W-1:0] nout;
    } t_act_ctl;

    typedef struct packed {
        logic              wr;
        logic [NODE_W-1:0] idx;
        t_data             y;
        logic              done;
    } t_act_st;

endpackage

`default_nettype wire

// ===== src/mlpf_cell.sv =====
// ----------------------------------------------------------------------------
// mlpf_cell
// One MAC cell of the chain: holds one node's weights and biases, forwards
// the input token to its neighbor and accumulates a saturating dot product.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpf_cell (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  [mlpf_pkg::LAYER_W-1:0]       i_layer,
    input  mlpf_pkg::t_wr                      i_wr,
    input  mlpf_pkg::t_tok                     i_tok,
    output mlpf_pkg::t_tok                     o_tok,
    output mlpf_pkg::t_data                    o_z,
    output logic                               o_done
);

    localparam int DEPTH = 1 << mlpf_pkg::MEM_AW;

    mlpf_pkg::t_data r_wmem [0:DEPTH-1];
    mlpf_pkg::t_data r_bias [0:mlpf_pkg::MAX_LAYERS-1];

    mlpf_pkg::t_tok    r_tok1;
    mlpf_pkg::t_data   r_w;
    logic signed [31:0] r_prod;
    logic               r_v2, r_f2, r_l2;
    logic signed [31:0] r_acc;
    logic               r_done;

    logic signed [31:0] base;
    logic signed [32:0] sum;
    logic signed [31:0] n_acc;
    logic signed [23:0] sh;

    always_ff @(posedge i_clk) begin
        if (i_wr.w_en) begin
            r_wmem[{i_wr.layer, i_wr.src}] <= i_wr.val;
        end
        r_w <= r_wmem[{i_layer, i_tok.s}];
        if (i_wr.b_en) begin
            r_bias[i_wr.layer] <= i_wr.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok1.valid <= 1'b0;
            r_v2         <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_tok1 <= i_tok;
            r_v2   <= r_tok1.valid;
            r_done <= r_v2 & r_l2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_w * r_tok1.x;
        r_f2   <= r_tok1.first;
        r_l2   <= r_tok1.last;
        if (r_v2) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        base = r_f2 ? 32'(r_bias[i_layer]) <<< 8 : r_acc;
        sum  = 33'(base) + 33'(r_prod);
        if (sum[32] != sum[31]) begin
            n_acc = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            n_acc = sum[31:0];
        end
    end

    always_comb begin
        sh = r_acc[31:8];
        if (sh[23] && (sh[22:15] != 8'hff)) begin
            o_z = 16'sh8000;
        end else if (!sh[23] && (sh[22:15] != 8'h00)) begin
            o_z = 16'sh7fff;
        end else begin
            o_z = sh[15:0];
        end
    end

    assign o_tok  = r_tok1;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== src/mlpf_act.sv =====
// ----------------------------------------------------------------------------
// mlpf_act
// Activation sequencer: sigmoid, rectifier, softmax or zeros over one
// layer's sums, one node at a time, with table exp, table log and a
// bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpf_act (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mlpf_pkg::t_act_ctl   i_ctl,
    input  mlpf_pkg::t_dvec      i_z,
    output mlpf_pkg::t_act_st    o_st
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_SIMPLE = 14'b00000000000010,
        S_MAX    = 14'b00000000000100,
        S_SIG0   = 14'b00000000001000,
        S_SUMU   = 14'b00000000010000,
        S_OUTU   = 14'b00000000100000,
        S_EXP0   = 14'b00000001000000,
        S_EXP1   = 14'b00000010000000,
        S_EXP2   = 14'b00000100000000,
        S_DIV    = 14'b00001000000000,
        S_LN0    = 14'b00010000000000,
        S_LN1    = 14'b00100000000000,
        S_LN2    = 14'b01000000000000,
        S_FIN    = 14'b10000000000000
    } t_state;

    typedef enum logic [1:0] {
        PH_SIG = 2'd0,
        PH_SUM = 2'd1,
        PH_OUT = 2'd2
    } t_phase;

    function automatic logic [16:0] ek(input logic [8:0] k);
        logic [16:0] r;
        unique case (k)
            9'd0:    r = 17'd65536;
            9'd1:    r = 17'd24109;
            9'd2:    r = 17'd8869;
            9'd3:    r = 17'd3263;
            9'd4:    r = 17'd1200;
            9'd5:    r = 17'd442;
            9'd6:    r = 17'd162;
            9'd7:    r = 17'd60;
            9'd8:    r = 17'd22;
            9'd9:    r = 17'd8;
            9'd10:   r = 17'd3;
            9'd11:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] eh(input logic [3:0] h);
        logic [16:0] r;
        unique case (h)
            4'd0:  r = 17'd65536;
            4'd1:  r = 17'd61565;
            4'd2:  r = 17'd57835;
            4'd3:  r = 17'd54331;
            4'd4:  r = 17'd51039;
            4'd5:  r = 17'd47947;
            4'd6:  r = 17'd45042;
            4'd7:  r = 17'd42313;
            4'd8:  r = 17'd39750;
            4'd9:  r = 17'd37341;
            4'd10: r = 17'd35079;
            4'd11: r = 17'd32954;
            4'd12: r = 17'd30957;
            4'd13: r = 17'd29081;
            4'd14: r = 17'd27319;
            4'd15: r = 17'd25664;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] el(input logic [3:0] l);
        logic [16:0] r;
        unique case (l)
            4'd0:  r = 17'd65536;
            4'd1:  r = 17'd65280;
            4'd2:  r = 17'd65026;
            4'd3:  r = 17'd64772;
            4'd4:  r = 17'd64520;
            4'd5:  r = 17'd64268;
            4'd6:  r = 17'd64018;
            4'd7:  r = 17'd63768;
            4'd8:  r = 17'd63520;
            4'd9:  r = 17'd63272;
            4'd10: r = 17'd63025;
            4'd11: r = 17'd62780;
            4'd12: r = 17'd62535;
            4'd13: r = 17'd62291;
            4'd14: r = 17'd62048;
            4'd15: r = 17'd61806;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] lnt(input logic [4:0] j);
        logic [15:0] r;
        unique case (j)
            5'd0:  r = 16'd0;
            5'd1:  r = 16'd3973;
            5'd2:  r = 16'd7719;
            5'd3:  r = 16'd11262;
            5'd4:  r = 16'd14624;
            5'd5:  r = 16'd17821;
            5'd6:  r = 16'd20870;
            5'd7:  r = 16'd23783;
            5'd8:  r = 16'd26573;
            5'd9:  r = 16'd29248;
            5'd10: r = 16'd31818;
            5'd11: r = 16'd34292;
            5'd12: r = 16'd36675;
            5'd13: r = 16'd38975;
            5'd14: r = 16'd41196;
            5'd15: r = 16'd43345;
            default: r = 16'd45426;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] rnd16(input logic [33:0] p);
        logic [33:0] t;
        t = p + 34'd32768;
        return t[32:16];
    endfunction

    function automatic logic [16:0] abs17(input mlpf_pkg::t_data z);
        logic signed [16:0] w;
        w = {z[15], z};
        return z[15] ? 17'(-w) : 17'(w);
    endfunction

    t_state  r_state, n_state;
    t_phase  r_ph, n_ph;
    logic [mlpf_pkg::NODE_W-1:0] r_i, n_i;
    logic [1:0]  r_kind, n_kind;
    logic [mlpf_pkg::CNT_W-1:0] r_nout, n_nout;
    mlpf_pkg::t_data r_m, n_m;
    logic [16:0] r_u, n_u;
    logic [33:0] r_p, n_p;
    logic [20:0] r_sum, n_sum;
    logic [2:0]  r_n, n_n;
    logic [3:0]  r_j, n_j;
    logic [11:0] r_t, n_t;
    logic [27:0] r_lp, n_lp;
    logic [9:0]  r_l8, n_l8;
    logic [17:0] r_d, n_d;
    logic [24:0] r_num, n_num;
    logic [17:0] r_rem, n_rem;
    logic [15:0] r_q, n_q;
    logic [4:0]  r_dc, n_dc;
    mlpf_pkg::t_act_st r_st, n_st;

    mlpf_pkg::t_data z_cur;
    logic        last_i;
    logic [16:0] e;
    logic [16:0] mz;
    logic [18:0] rem_sh;
    logic        ge;
    logic [20:0] ln_base, ln_diff;
    logic [15:0] ln_f;
    logic [19:0] ln_sum;
    logic [15:0] ln_step;

    assign z_cur  = i_z[r_i];
    assign last_i = ({1'b0, r_i} == (r_nout - 5'd1));
    assign e      = rnd16(r_p);
    assign mz     = 17'($signed({r_m[15], r_m}) - $signed({z_cur[15], z_cur}));
    assign rem_sh = {r_rem, r_num[24]};
    assign ge     = (rem_sh >= {1'b0, r_d});

    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_i     = r_i;
        n_kind  = r_kind;
        n_nout  = r_nout;
        n_m     = r_m;
        n_u     = r_u;
        n_p     = r_p;
        n_sum   = r_sum;
        n_n     = r_n;
        n_j     = r_j;
        n_t     = r_t;
        n_lp    = r_lp;
        n_l8    = r_l8;
        n_d     = r_d;
        n_num   = r_num;
        n_rem   = r_rem;
        n_q     = r_q;
        n_dc    = r_dc;
        n_st    = '0;
        n_st.idx = r_i;
        ln_base = 21'd0;
        ln_diff = 21'd0;
        ln_f    = 16'd0;
        ln_sum  = 20'd0;
        ln_step = 16'd0;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_kind = i_ctl.kind;
                    n_nout = i_ctl.nout;
                    n_i    = '0;
                    n_m    = i_z[0];
                    unique case (i_ctl.kind)
                        mlpf_pkg::KIND_SIGMOID: n_state = S_SIG0;
                        mlpf_pkg::KIND_SOFTMAX: n_state = S_MAX;
                        default:                n_state = S_SIMPLE;
                    endcase
                end
            end
            S_SIMPLE: begin
                n_st.wr = 1'b1;
                n_st.y  = (r_kind == mlpf_pkg::KIND_RELU && z_cur > 0) ? z_cur : '0;
                if (last_i) n_state = S_FIN;
                else n_i = r_i + 4'd1;
            end
            S_MAX: begin
                if (z_cur > r_m) n_m = z_cur;
                if (last_i) begin
                    n_i     = '0;
                    n_sum   = '0;
                    n_state = S_SUMU;
                end else begin
                    n_i = r_i + 4'd1;
                end
            end
            S_SIG0: begin
                n_u     = abs17(z_cur);
                n_ph    = PH_SIG;
                n_state = S_EXP0;
            end
            S_SUMU: begin
                n_u     = mz;
                n_ph    = PH_SUM;
                n_state = S_EXP0;
            end
            S_OUTU: begin
                n_u     = mz + {7'd0, r_l8};
                n_ph    = PH_OUT;
                n_state = S_EXP0;
            end
            S_EXP0: begin
                n_p     = 34'(ek(r_u[16:8])) * 34'(eh(r_u[7:4]));
                n_state = S_EXP1;
            end
            S_EXP1: begin
                n_p     = 34'(rnd16(r_p)) * 34'(el(r_u[3:0]));
                n_state = S_EXP2;
            end
            S_EXP2: begin
                unique case (r_ph)
                    PH_SIG: begin
                        n_d   = 18'd65536 + {1'b0, e};
                        n_num = z_cur[15] ? ({e, 8'd0} + 25'(n_d >> 1))
                                          : (25'd16777216 + 25'(n_d >> 1));
                        n_rem   = '0;
                        n_q     = '0;
                        n_dc    = 5'd24;
                        n_state = S_DIV;
                    end
                    PH_SUM: begin
                        n_sum = r_sum + {4'd0, e};
                        if (last_i) n_state = S_LN0;
                        else begin
                            n_i     = r_i + 4'd1;
                            n_state = S_SUMU;
                        end
                    end
                    default: begin
                        n_st.wr = 1'b1;
                        n_st.y  = 16'((e + 17'd128) >> 8);
                        if (last_i) n_state = S_FIN;
                        else begin
                            n_i     = r_i + 4'd1;
                            n_state = S_OUTU;
                        end
                    end
                endcase
            end
            S_DIV: begin
                n_rem = ge ? 18'(rem_sh - {1'b0, r_d}) : rem_sh[17:0];
                n_num = {r_num[23:0], 1'b0};
                n_q   = {r_q[14:0], ge};
                n_dc  = r_dc - 5'd1;
                if (r_dc == 5'd0) begin
                    n_st.wr = 1'b1;
                    n_st.y  = n_q;
                    if (last_i) n_state = S_FIN;
                    else begin
                        n_i     = r_i + 4'd1;
                        n_state = S_SIG0;
                    end
                end
            end
            S_LN0: begin
                priority if (r_sum[20]) n_n = 3'd4;
                else if (r_sum[19])     n_n = 3'd3;
                else if (r_sum[18])     n_n = 3'd2;
                else if (r_sum[17])     n_n = 3'd1;
                else                    n_n = 3'd0;
                ln_base = 21'd1 << (5'd16 + {2'd0, n_n});
                ln_diff = r_sum - ln_base;
                ln_f    = 16'(ln_diff >> n_n);
                n_j     = ln_f[15:12];
                n_t     = ln_f[11:0];
                n_state = S_LN1;
            end
            S_LN1: begin
                ln_step = lnt({1'b0, r_j} + 5'd1) - lnt({1'b0, r_j});
                n_lp    = 28'(ln_step) * 28'(r_t);
                n_state = S_LN2;
            end
            S_LN2: begin
                ln_sum  = 20'(r_n) * 20'd45426 + 20'(lnt({1'b0, r_j}))
                        + 20'((r_lp + 28'd2048) >> 12);
                n_l8    = 10'((ln_sum + 20'd128) >> 8);
                n_i     = '0;
                n_state = S_OUTU;
            end
            S_FIN: begin
                n_st.done = 1'b1;
                n_i       = '0;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_st    <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_st    <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ph   <= n_ph;
        r_kind <= n_kind;
        r_nout <= n_nout;
        r_m    <= n_m;
        r_u    <= n_u;
        r_p    <= n_p;
        r_sum  <= n_sum;
        r_n    <= n_n;
        r_j    <= n_j;
        r_t    <= n_t;
        r_lp   <= n_lp;
        r_l8   <= n_l8;
        r_d    <= n_d;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_dc   <= n_dc;
    end

    assign o_st = r_st;

endmodule

`default_nettype wire

// ===== src/mlp_forward_inference_core.sv =====
// ----------------------------------------------------------------------------
// mlp_forward_inference_core
// Dense MLP forward pass: a chain of sixteen MAC cells forms the node sums
// of one layer, an activation sequencer finishes it, layers run in turn.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                   payload
//  in        in   i_in_valid / o_in_stall     i_in  (t_in_item)
//  out       out  o_out_valid / i_out_stall   o_out (t_out_item)
//  cfg       in   i_cfg_we                    i_cfg_idx, i_cfg_data
//
//  Weight, bias and plain feature requests are taken one per cycle while idle.
//  A last feature starts a pass: per layer the cell chain forms the sums,
//  then the sequencer applies the rectifier, zeros, sigmoid (25-step
//  divider) or softmax, and the results follow one per cycle while the
//  output does not stall. Inputs stall for the whole pass.
//  Synchronous active-low reset; stores need no clearing pass.
`default_nettype none

module mlp_forward_inference_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  mlpf_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output mlpf_pkg::t_out_item                 o_out,
    input  wire                                 i_cfg_we,
    input  wire  [mlpf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [mlpf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FEED = 5'b00010,
        S_WAIT = 5'b00100,
        S_ACT  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    localparam int N = mlpf_pkg::MAX_NODES;

    function automatic logic [4:0] clamp_cnt(input logic [4:0] v);
        if (v == 5'd0) return 5'd1;
        if (v > 5'd16) return 5'd16;
        return v;
    endfunction

    t_state r_state;
    logic [2:0] r_layers;
    logic [4:0] r_inw;
    logic [4:0] r_nodes [0:mlpf_pkg::MAX_LAYERS-1];
    logic [7:0] r_kinds;
    mlpf_pkg::t_data r_front [0:N-1];
    mlpf_pkg::t_data r_cur [0:N-1];
    logic [mlpf_pkg::LAYER_W-1:0] r_layer;
    logic [mlpf_pkg::NODE_W-1:0]  r_s;
    logic [4:0] r_nin;
    mlpf_pkg::t_tok r_feed;
    logic r_act_start;
    logic r_ovalid;
    mlpf_pkg::t_out_item r_out;
    logic [4:0] r_oi;
    logic [4:0] r_seen;

    logic in_acc, out_acc;
    logic [4:0] cur_nout;
    logic [2:0] layers_c;
    logic feed_last;
    mlpf_pkg::t_tok   tok [0:N-1];
    mlpf_pkg::t_dvec  z_vec;
    logic             done [0:N-1];
    mlpf_pkg::t_act_ctl act_ctl;
    mlpf_pkg::t_act_st  act_st;

    assign in_acc    = i_in_valid & ~o_in_stall;
    assign out_acc   = r_ovalid & ~i_out_stall;
    assign cur_nout  = clamp_cnt(r_nodes[r_layer]);
    assign layers_c  = (r_layers == 3'd0) ? 3'd1 : ((r_layers > 3'd4) ? 3'd4 : r_layers);
    assign feed_last = ({1'b0, r_s} == (r_nin - 5'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layers <= 3'd1;
            r_inw    <= 5'd16;
            for (int k = 0; k < mlpf_pkg::MAX_LAYERS; k++) r_nodes[k] <= 5'd16;
            r_kinds  <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mlpf_pkg::CFG_LAYERS: r_layers   <= i_cfg_data[2:0];
                mlpf_pkg::CFG_INPUTS: r_inw      <= i_cfg_data[4:0];
                mlpf_pkg::CFG_NODES0: r_nodes[0] <= i_cfg_data[4:0];
                mlpf_pkg::CFG_NODES1: r_nodes[1] <= i_cfg_data[4:0];
                mlpf_pkg::CFG_NODES2: r_nodes[2] <= i_cfg_data[4:0];
                mlpf_pkg::CFG_NODES3: r_nodes[3] <= i_cfg_data[4:0];
                mlpf_pkg::CFG_KINDS:  r_kinds    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.action == mlpf_pkg::ACT_FEATURE) begin
            r_front[i_in.source_index] <= i_in.value;
        end
        if (act_st.wr) begin
            r_cur[act_st.idx] <= act_st.y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_layer      <= '0;
            r_s          <= '0;
            r_feed.valid <= 1'b0;
            r_act_start  <= 1'b0;
            r_ovalid     <= 1'b0;
            r_oi         <= '0;
            r_seen       <= '0;
        end else begin
            r_feed.valid <= 1'b0;
            r_act_start  <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in.action == mlpf_pkg::ACT_FEATURE) begin
                        if (i_in.last_feature) begin
                            r_seen  <= '0;
                            r_layer <= '0;
                            r_s     <= '0;
                            r_nin   <= clamp_cnt(r_inw);
                            r_state <= S_FEED;
                        end else if (r_seen != 5'd31) begin
                            r_seen <= r_seen + 5'd1;
                        end
                    end
                end
                S_FEED: begin
                    r_feed.valid <= 1'b1;
                    r_feed.first <= (r_s == '0);
                    r_feed.last  <= feed_last;
                    r_feed.s     <= r_s;
                    r_feed.x     <= (r_layer == '0) ? r_front[r_s] : r_cur[r_s];
                    r_s          <= r_s + 4'd1;
                    if (feed_last) begin
                        r_s     <= '0;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (done[N-1]) begin
                        r_act_start <= 1'b1;
                        r_state     <= S_ACT;
                    end
                end
                S_ACT: begin
                    if (act_st.done) begin
                        if ({1'b0, r_layer} == (layers_c - 3'd1)) begin
                            r_oi    <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_layer <= r_layer + 2'd1;
                            r_nin   <= cur_nout;
                            r_state <= S_FEED;
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid || out_acc) begin
                        if (r_oi < cur_nout) begin
                            r_ovalid           <= 1'b1;
                            r_out.result_value <= r_cur[r_oi[3:0]];
                            r_out.result_index <= r_oi[3:0];
                            r_out.last_result  <= ((r_oi + 5'd1) == cur_nout);
                            r_oi               <= r_oi + 5'd1;
                        end else begin
                            r_ovalid <= 1'b0;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            mlpf_pkg::t_wr wr;
            assign wr.w_en  = in_acc && (i_in.action == mlpf_pkg::ACT_WEIGHT)
                              && (i_in.node_index == mlpf_pkg::NODE_W'(g));
            assign wr.b_en  = in_acc && (i_in.action == mlpf_pkg::ACT_BIAS)
                              && (i_in.node_index == mlpf_pkg::NODE_W'(g));
            assign wr.layer = i_in.layer_index;
            assign wr.src   = i_in.source_index;
            assign wr.val   = i_in.value;

            mlpf_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_layer (r_layer),
                .i_wr    (wr),
                .i_tok   ((g == 0) ? r_feed : tok[(g == 0) ? 0 : g - 1]),
                .o_tok   (tok[g]),
                .o_z     (z_vec[g]),
                .o_done  (done[g])
            );
        end
    endgenerate

    assign act_ctl.start = r_act_start;
    assign act_ctl.kind  = r_kinds[2 * r_layer +: 2];
    assign act_ctl.nout  = cur_nout;

    mlpf_act u_act (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (act_ctl),
        .i_z     (z_vec),
        .o_st    (act_st)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_out_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == S_EMIT))
        else $error("result valid outside emit");
    a_chain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done[N-1] |-> (r_state == S_WAIT))
        else $error("cell chain finished outside wait");
    a_act_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        act_st.wr |-> (r_state == S_ACT))
        else $error("activation write outside activation phase");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_out.result_index} < cur_nout))
        else $error("result index beyond node count");
`endif

endmodule

`default_nettype wire
